/* design/huffman_bit_packer_core_assert.svh */
// Assertion macros for the Huffman bit packer core.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/hbp_pkg.sv */
// Shared types and constants for the Huffman bit packer core.
// No dependencies.
`default_nettype none

package hbp_pkg;

	localparam int BYTE_BITS = 8;
	localparam int NUM_OUT   = 4;
	localparam int WORD_W    = BYTE_BITS * NUM_OUT;
	localparam int LEN_W     = 6;
	localparam int PEND_W    = 7;
	localparam int CNT_W     = 3;
	localparam int PAD_W     = 4;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  count;
		logic [PAD_W-1:0]  pad;
		logic              is_final;
	} emit_load_t;

endpackage

`default_nettype wire

/* design/hbp_table.sv */
// Code table: one synchronous memory of code word and length per symbol,
// with a reset-cleared valid bit per entry. Depends on hbp_pkg.
`default_nettype none

module hbp_table #(
	parameter int SYMBOL_COUNT = 256,
	parameter int IDX_W        = 8,
	parameter int CODE_W       = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [IDX_W-1:0]         wr_idx,
	input  wire logic [CODE_W-1:0]        wr_code,
	input  wire logic [hbp_pkg::LEN_W-1:0] wr_len,
	input  wire logic                     rd_en,
	input  wire logic [IDX_W-1:0]         rd_idx,
	output logic      [CODE_W-1:0]        rd_code,
	output logic      [hbp_pkg::LEN_W-1:0] rd_len
);
	import hbp_pkg::*;

	logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] entry_valid_q;
	logic [CODE_W+LEN_W-1:0] rd_data_s1;
	logic                    rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_code, wr_len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1  <= mem[rd_idx];
			rd_valid_s1 <= entry_valid_q[rd_idx];
		end
	end

	assign rd_code = rd_data_s1[CODE_W+LEN_W-1:LEN_W];
	assign rd_len  = rd_valid_s1 ? rd_data_s1[LEN_W-1:0] : '0;

endmodule

`default_nettype wire

/* design/hbp_pack.sv */
// Packing stage: merges the looked-up code with the pending bits, updates
// the pending state and hands whole bytes to the emitter. Depends on hbp_pkg.
`default_nettype none

module hbp_pack #(
	parameter int CODE_W = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire hbp_pkg::cmd_t             cmd,
	input  wire logic                      in_range,
	input  wire logic [CODE_W-1:0]         rd_code,
	input  wire logic [hbp_pkg::LEN_W-1:0] rd_len,
	input  wire logic                      emit_free,
	output hbp_pkg::emit_load_t            emit_load,
	output logic                           in_stall
);
	import hbp_pkg::*;

	localparam int ACC_W = CODE_W + PEND_W;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              in_range_s1;
	logic [PEND_W-1:0] pend_bits_q;
	logic [CNT_W-1:0]  pend_cnt_q;

	logic [LEN_W-1:0]  clen;
	logic [ACC_W-1:0]  code_ext;
	logic [ACC_W-1:0]  acc;
	logic [5:0]        total;
	logic [CNT_W-1:0]  nbytes;
	logic [CNT_W-1:0]  rem;
	logic [WORD_W-1:0] bytes_r;
	logic [WORD_W-1:0] word_al;
	logic [PEND_W-1:0] new_pend;
	logic [PAD_W-1:0]  pad;
	logic [7:0]        flush_byte;
	logic              go;

	always_comb begin
		clen       = in_range_s1 ? rd_len : '0;
		code_ext   = ACC_W'(rd_code) & ((ACC_W'(1) << clen) - ACC_W'(1));
		acc        = (ACC_W'(pend_bits_q) << clen) | code_ext;
		total      = {3'b000, pend_cnt_q} + 6'(clen);
		nbytes     = total[5:3];
		rem        = total[2:0];
		bytes_r    = WORD_W'(acc >> rem);
		word_al    = bytes_r << {3'(NUM_OUT) - nbytes, 3'b000};
		new_pend   = acc[PEND_W-1:0] & PEND_W'((8'd1 << rem) - 8'd1);
		pad        = PAD_W'(BYTE_BITS) - {1'b0, pend_cnt_q};
		flush_byte = 8'(15'(pend_bits_q) << pad);
	end

	always_comb begin
		go        = 1'b1;
		emit_load = '0;
		if (valid_s1) begin
			unique case (cmd_s1)
				CMD_ENCODE: begin
					if (nbytes != '0) begin
						go                 = emit_free;
						emit_load.valid    = emit_free;
						emit_load.word     = word_al;
						emit_load.count    = nbytes;
					end
				end
				CMD_FLUSH: begin
					go                 = emit_free;
					emit_load.valid    = emit_free;
					emit_load.word     = {flush_byte, (WORD_W - BYTE_BITS)'(0)};
					emit_load.count    = CNT_W'(1);
					emit_load.pad      = pad;
					emit_load.is_final = 1'b1;
				end
				default: begin
					go = 1'b1;
				end
			endcase
		end
	end

	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept && (cmd == CMD_ENCODE || cmd == CMD_FLUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			cmd_s1      <= cmd;
			in_range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (valid_s1 && go) begin
			if (cmd_s1 == CMD_ENCODE) begin
				pend_bits_q <= new_pend;
				pend_cnt_q  <= rem;
			end else if (cmd_s1 == CMD_FLUSH) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/hbp_emit.sv */
// Output stage: holds up to four packed bytes and presents one per
// transaction, top byte first. Depends on hbp_pkg.
`default_nettype none

module hbp_emit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire hbp_pkg::emit_load_t      emit_load,
	output logic                          emit_free,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_byte,
	output logic [hbp_pkg::PAD_W-1:0]     pad_bits,
	output logic                          is_final,
	output logic                          last
);
	import hbp_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  count_q;
	logic [PAD_W-1:0]  pad_q;
	logic              is_final_q;

	assign emit_free = (count_q == '0) || (count_q == CNT_W'(1) && !out_stall);
	assign out_valid = count_q != '0;
	assign out_byte  = word_q[WORD_W-1 -: BYTE_BITS];
	assign pad_bits  = pad_q;
	assign is_final  = is_final_q;
	assign last      = count_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (emit_load.valid) begin
			count_q <= emit_load.count;
		end else if (out_valid && !out_stall) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load.valid) begin
			word_q     <= emit_load.word;
			pad_q      <= emit_load.pad;
			is_final_q <= emit_load.is_final;
		end else if (out_valid && !out_stall) begin
			word_q <= word_q << BYTE_BITS;
		end
	end

endmodule

`default_nettype wire

/* design/huffman_bit_packer_core.sv */
// Huffman encoder back end. Load transactions write a code word and length
// into the code table, encode transactions append a symbol's code to the bit
// accumulator, and flush transactions emit the padded final byte. The table
// read for an encode and the packing stage's command are registered when the
// transaction is accepted, and the output stage registers the packed bytes,
// or the flushed byte, once it is free. The output stage sends one byte per
// cycle while out_stall is low. An encode that yields bytes (at most four)
// holds it until each has been sent, and a following transaction that yields
// bytes waits in the packing stage until the last of them is taken, so such a
// stream is accepted no faster than its bytes leave. Otherwise a new
// transaction is accepted every cycle. The table needs no clearing pass after
// reset. Depends on hbp_pkg, hbp_table, hbp_pack and hbp_emit.
`default_nettype none

`include "huffman_bit_packer_core_assert.svh"

module huffman_bit_packer_core #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                command,
	input  wire logic [7:0]                symbol,
	input  wire logic [31:0]               code_word,
	input  wire logic [hbp_pkg::LEN_W-1:0] code_length,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     out_byte,
	output logic [hbp_pkg::PAD_W-1:0]      pad_bits,
	output logic                           is_final,
	output logic                           last
);
	import hbp_pkg::*;

	localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int IDX_W  = $clog2(SYMBOL_COUNT);

	cmd_t             cmd;
	logic             accept;
	logic             in_range;
	logic [LEN_W-1:0] len_sat;
	logic             wr_en;
	logic             rd_en;
	logic [CODE_W-1:0] rd_code;
	logic [LEN_W-1:0] rd_len;
	emit_load_t       emit_load;
	logic             emit_free;

	assign cmd      = cmd_t'(command);
	assign accept   = in_valid && !in_stall;
	assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign len_sat  = (code_length > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : code_length;
	assign wr_en    = accept && cmd == CMD_LOAD && in_range;
	assign rd_en    = accept && cmd == CMD_ENCODE;

	hbp_table #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.IDX_W(IDX_W),
		.CODE_W(CODE_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_idx(symbol[IDX_W-1:0]),
		.wr_code(code_word[CODE_W-1:0]),
		.wr_len(len_sat),
		.rd_en(rd_en),
		.rd_idx(symbol[IDX_W-1:0]),
		.rd_code(rd_code),
		.rd_len(rd_len)
	);

	hbp_pack #(
		.CODE_W(CODE_W)
	) u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(cmd),
		.in_range(in_range),
		.rd_code(rd_code),
		.rd_len(rd_len),
		.emit_free(emit_free),
		.emit_load(emit_load),
		.in_stall(in_stall)
	);

	hbp_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.emit_load(emit_load),
		.emit_free(emit_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.pad_bits(pad_bits),
		.is_final(is_final),
		.last(last)
	);

	`HBP_ASSERT_IMP(a_final_single, out_valid && is_final, last && pad_bits != '0, "bad final byte")
	`HBP_ASSERT_IMP(a_stall_busy, in_stall, out_valid, "input stalled with empty output stage")
	`HBP_ASSERT_IMP(a_load_free, emit_load.valid, emit_free, "output stage loaded while busy")
	`HBP_ASSERT_NXT(a_burst_cont, out_valid && !out_stall && !last, out_valid, "byte burst cut short")

endmodule

`default_nettype wire
